// ----- rtl/core/mp2d_pkg.sv -----
package mp2d_pkg;

    // Fixed field widths of the configuration registers
    localparam int WIN_BITS      = 3;
    localparam int DIM_BITS      = 10;
    localparam int REG_BITS      = 11;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 4;

    // Register indexes on the configuration port (byte address / 4)
    typedef enum logic [1:0] {
        REG_WINDOW   = 2'd0,
        REG_WIDTH    = 2'd1,
        REG_HEIGHT   = 2'd2,
        REG_CHANNELS = 2'd3
    } reg_idx_t;

    // Clamped last indexes derived from the configuration registers
    typedef struct packed {
        logic [WIN_BITS-1:0] win_last;
        logic [DIM_BITS-1:0] height_last;
        logic [DIM_BITS-1:0] chan_last;
    } limits_t;

endpackage

// ----- rtl/core/max_pool_2d_stream.sv -----
// Path: a pooled value passes through the compare stage register and then the output register
// before it reaches m_tdata. Throughput: one sample beat per cycle unless the compare stage
// is held by a stalled output; the column store is read and written at most once a cycle.
// Reset: rst_n clears counters, running maximum, valid flags and the registers to their defaults;
// the column store is not cleared, as every entry is written on the first row of a window.
module max_pool_2d_stream
    import mp2d_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [CFG_ADDR_BITS-1:0]               paddr,
    input  logic [CFG_DATA_BITS-1:0]               pwdata,
    output logic [CFG_DATA_BITS-1:0]               prdata,
    output logic                                   pready,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [SAMPLE_BITS-1:0] sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [SAMPLE_BITS-2:0] pooled_value
    output logic [((SAMPLE_BITS+6)/8)*8-1:0]       m_tdata,
    output logic                                   m_tlast,
    // [0] end_of_tensor
    output logic                                   m_tuser
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int VB    = SAMPLE_BITS - 1;
    localparam int OUT_W = ((SAMPLE_BITS + 6) / 8) * 8;

    limits_t         lim;
    logic [CW-1:0]   width_last;
    logic            restart;

    // Window tracking state
    logic [CW-1:0]       col_pos_reg, col_pos_next;
    logic [CW-1:0]       oc_reg, oc_next;
    logic [DIM_BITS-1:0] row_pos_reg, row_pos_next;
    logic [DIM_BITS-1:0] ch_reg, ch_next;
    logic [WIN_BITS-1:0] ciw_reg, ciw_next;
    logic [WIN_BITS-1:0] riw_reg, riw_next;
    logic [VB-1:0]       run_max_reg, run_max_next;

    // Compare stage
    logic                p1_valid_reg, p1_valid_next;
    logic [VB-1:0]       p1_seg_reg;
    logic [CW-1:0]       p1_addr_reg;
    logic                p1_use_prev_reg;
    logic                p1_win_end_reg;
    logic                p1_eop_reg;
    logic                p1_eot_reg;
    logic                byp_valid_reg;
    logic [VB-1:0]       byp_data_reg;
    logic [VB-1:0]       rd_data_reg;
    logic [VB-1:0]       store [MAX_WIDTH];

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [VB-1:0]       out_value_reg;
    logic                out_eop_reg;
    logic                out_eot_reg;

    logic                accept;
    logic                load_p1;
    logic                p1_go;
    logic [VB-1:0]       sample_val;
    logic [VB-1:0]       seg;
    logic [VB-1:0]       prev;
    logic [VB-1:0]       pooled;
    logic                last_col;
    logic                last_row;
    logic                last_chan;
    logic                closing;
    logic                win_end;

    mp2d_cfg #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .limits     (lim),
        .width_last (width_last),
        .restart    (restart)
    );

    // Handshake: take a beat whenever the compare stage is empty or moving on
    assign p1_go    = p1_valid_reg && (!p1_win_end_reg || !out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_go;
    assign accept   = s_tvalid && s_tready;

    // Floor negative samples at zero
    assign sample_val = s_tdata[SAMPLE_BITS-1] ? '0 : s_tdata[SAMPLE_BITS-2:0];
    assign seg = ((ciw_reg == '0) || (sample_val > run_max_reg)) ? sample_val : run_max_reg;

    assign last_col  = col_pos_reg >= width_last;
    assign closing   = (ciw_reg >= lim.win_last) || last_col;
    assign last_row  = row_pos_reg >= lim.height_last;
    assign win_end   = (riw_reg >= lim.win_last) || last_row;
    assign last_chan = ch_reg >= lim.chan_last;
    assign load_p1   = accept && closing;

    // Advance the raster position and window counters
    always_comb
    begin
        col_pos_next = col_pos_reg;
        oc_next      = oc_reg;
        row_pos_next = row_pos_reg;
        ch_next      = ch_reg;
        ciw_next     = ciw_reg;
        riw_next     = riw_reg;
        run_max_next = run_max_reg;
        if (accept)
        begin
            if (!closing)
            begin
                run_max_next = seg;
                ciw_next     = ciw_reg + WIN_BITS'(1);
                col_pos_next = col_pos_reg + CW'(1);
            end
            else
            begin
                run_max_next = '0;
                ciw_next     = '0;
                if (last_col)
                begin
                    col_pos_next = '0;
                    oc_next      = '0;
                    if (last_row)
                    begin
                        row_pos_next = '0;
                        riw_next     = '0;
                        ch_next      = last_chan ? '0 : ch_reg + DIM_BITS'(1);
                    end
                    else
                    begin
                        row_pos_next = row_pos_reg + DIM_BITS'(1);
                        riw_next     = win_end ? '0 : riw_reg + WIN_BITS'(1);
                    end
                end
                else
                begin
                    col_pos_next = col_pos_reg + CW'(1);
                    oc_next      = oc_reg + CW'(1);
                end
            end
        end
        // Restart the stream on any register write
        if (restart)
        begin
            col_pos_next = '0;
            oc_next      = '0;
            row_pos_next = '0;
            ch_next      = '0;
            ciw_next     = '0;
            riw_next     = '0;
            run_max_next = '0;
        end
    end

    // Merge the segment with the rows stored so far
    always_comb
    begin
        if (!p1_use_prev_reg)
            prev = '0;
        else if (byp_valid_reg)
            prev = byp_data_reg;
        else
            prev = rd_data_reg;
        pooled = (p1_seg_reg > prev) ? p1_seg_reg : prev;
    end

    assign p1_valid_next  = load_p1 ? 1'b1 : (p1_go ? 1'b0 : p1_valid_reg);
    assign out_valid_next = (p1_go && p1_win_end_reg) ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg   <= '0;
            oc_reg        <= '0;
            row_pos_reg   <= '0;
            ch_reg        <= '0;
            ciw_reg       <= '0;
            riw_reg       <= '0;
            run_max_reg   <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_pos_reg   <= col_pos_next;
            oc_reg        <= oc_next;
            row_pos_reg   <= row_pos_next;
            ch_reg        <= ch_next;
            ciw_reg       <= ciw_next;
            riw_reg       <= riw_next;
            run_max_reg   <= run_max_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the compare stage; forward the value written in the same cycle
    always_ff @(posedge clk)
    begin
        if (load_p1)
        begin
            p1_seg_reg      <= seg;
            p1_addr_reg     <= oc_reg;
            p1_use_prev_reg <= riw_reg != '0;
            p1_win_end_reg  <= win_end;
            p1_eop_reg      <= last_col && last_row;
            p1_eot_reg      <= last_col && last_row && last_chan;
            byp_valid_reg   <= p1_valid_reg && (p1_addr_reg == oc_reg);
            byp_data_reg    <= pooled;
        end
    end

    // Column store: write the merged maximum, read for the next closing beat
    always_ff @(posedge clk)
    begin
        if (p1_go)
            store[p1_addr_reg] <= pooled;
        if (load_p1)
            rd_data_reg <= store[oc_reg];
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (p1_go && p1_win_end_reg)
        begin
            out_value_reg <= pooled;
            out_eop_reg   <= p1_eop_reg;
            out_eot_reg   <= p1_eot_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_value_reg);
    assign m_tlast  = out_eop_reg;
    assign m_tuser  = out_eot_reg;

    // A beat taken while the compare stage is full must find it draining
    a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && p1_valid_reg) |-> p1_go)
        else $error("compare stage overwritten while holding a beat");

    // Tensor end only on a plane end
    a_eot_on_eop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("end of tensor without end of plane");

    // Column position stays within the row
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        col_pos_reg <= width_last)
        else $error("column position beyond row end");

    // Pooled column never runs ahead of the input column
    a_oc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oc_reg <= col_pos_reg)
        else $error("output column ahead of input column");

endmodule

// ----- rtl/core/mp2d_cfg.sv -----
module mp2d_cfg
    import mp2d_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_BITS-1:0]      paddr,
    input  logic [CFG_DATA_BITS-1:0]      pwdata,
    output logic [CFG_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    output limits_t                       limits,
    output logic [$clog2(MAX_WIDTH)-1:0]  width_last,
    output logic                          restart
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [3:0]          window_reg;
    logic [REG_BITS-1:0] width_reg;
    logic [REG_BITS-1:0] height_reg;
    logic [REG_BITS-1:0] channels_reg;
    reg_idx_t            idx;

    // Clamp a dimension register to 1..1024 and return its last index
    function automatic logic [DIM_BITS-1:0] dim_last(input logic [REG_BITS-1:0] v);
        logic [DIM_BITS-1:0] r;
        if (v == '0)
            r = '0;
        else if (v > REG_BITS'(1 << DIM_BITS))
            r = '1;
        else
            r = DIM_BITS'(v - REG_BITS'(1));
        return r;
    endfunction

    assign idx     = reg_idx_t'(paddr[3:2]);
    assign pready  = 1'b1;
    assign restart = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= 4'd2;
            width_reg    <= 11'd1024;
            height_reg   <= 11'd1024;
            channels_reg <= 11'd1;
        end
        else if (restart)
        begin
            case (idx)
                REG_WINDOW:   window_reg   <= pwdata[3:0];
                REG_WIDTH:    width_reg    <= pwdata[REG_BITS-1:0];
                REG_HEIGHT:   height_reg   <= pwdata[REG_BITS-1:0];
                REG_CHANNELS: channels_reg <= pwdata[REG_BITS-1:0];
                default:      ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (idx)
            REG_WINDOW:   prdata = CFG_DATA_BITS'(window_reg);
            REG_WIDTH:    prdata = CFG_DATA_BITS'(width_reg);
            REG_HEIGHT:   prdata = CFG_DATA_BITS'(height_reg);
            REG_CHANNELS: prdata = CFG_DATA_BITS'(channels_reg);
            default:      prdata = '0;
        endcase
    end

    // Window side: zero acts as one, above eight saturates
    always_comb
    begin
        if (window_reg == 4'd0)
            limits.win_last = '0;
        else if (window_reg > 4'd8)
            limits.win_last = '1;
        else
            limits.win_last = WIN_BITS'(window_reg - 4'd1);
        limits.height_last = dim_last(height_reg);
        limits.chan_last   = dim_last(channels_reg);
    end

    // Row length: zero acts as one, above the store depth saturates
    always_comb
    begin
        if (width_reg == '0)
            width_last = '0;
        else if ({2'b00, width_reg} > 13'(MAX_WIDTH))
            width_last = CW'(MAX_WIDTH - 1);
        else
            width_last = CW'({2'b00, width_reg} - 13'd1);
    end

endmodule
